// ===== design/rsd_pkg.sv =====
// shared types and constants for the run-length sprite decoder
// no dependencies
package rsd_pkg;

  localparam int IMAGE_SIDE_DEF = 32;
  localparam int RUN_W          = 11;
  localparam int CNT_W          = 16;
  localparam int CONS_W         = 17;
  localparam int FIFO_DEPTH     = 4;

  localparam logic [CONS_W-1:0] CONSUMED_MAX = '1;
  localparam logic [7:0]        CHAN_FULL    = 8'hFF;
  localparam logic [7:0]        CHAN_ZERO    = 8'h00;
  localparam logic [2:0]        CHUNK_HDR_BYTES = 3'd4;
  localparam logic [2:0]        TRIPLET_BYTES   = 3'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_KEY,
    PH_SIZE,
    PH_CHUNK,
    PH_PIX,
    PH_DONE
  } rsd_phase_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [RUN_W-1:0] run_length;
    logic             end_of_image;
    logic             overflow;
  } rsd_run_t;

  typedef struct packed {
    logic [1:0]          cnt;
    rsd_run_t [1:0]      run;
  } rsd_emit_t;

endpackage

// ===== design/rsd_decoder.sv =====
// record parser: header and chunk state, builds up to two runs per byte
// depends on rsd_pkg
module rsd_decoder #(
  parameter int IMAGE_SIDE = rsd_pkg::IMAGE_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              record_start,
  output rsd_pkg::rsd_emit_t emit_o
);
  import rsd_pkg::*;

  localparam int TOTAL = IMAGE_SIDE * IMAGE_SIDE;
  localparam int POS_W = $clog2(TOTAL + 1);
  localparam logic [POS_W-1:0] TOTAL_P = POS_W'(TOTAL);

  rsd_phase_t        phase_r, phase_nxt;
  logic [1:0]        hidx_r, hidx_nxt;
  logic [CNT_W-1:0]  size_r, size_nxt;
  logic [CONS_W-1:0] cons_r, cons_nxt;
  logic [CNT_W-1:0]  clear_r, clear_nxt;
  logic [CNT_W-1:0]  colored_r, colored_nxt;
  logic [CNT_W-1:0]  latch_r, latch_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              ovf_r, ovf_nxt;

  logic [POS_W-1:0]  avail;
  logic              clip;
  logic [POS_W-1:0]  trans_len;
  logic [POS_W-1:0]  pos_after_trans;
  logic [CNT_W-1:0]  colored_full;
  logic              pix_room;
  logic [POS_W-1:0]  pos_after_pix;
  logic [CNT_W-1:0]  colored_dec;
  logic [CONS_W:0]   sum4, sum3;
  logic [CONS_W-1:0] cons4, cons3;
  rsd_emit_t         emit;

  assign avail           = TOTAL_P - pos_r;
  assign clip            = clear_r > CNT_W'(avail);
  assign trans_len       = clip ? avail : POS_W'(clear_r);
  assign pos_after_trans = pos_r + trans_len;
  assign colored_full    = {data_byte, colored_r[7:0]};
  assign pix_room        = pos_r < TOTAL_P;
  assign pos_after_pix   = pos_r + POS_W'(pix_room);
  assign colored_dec     = colored_r - CNT_W'(1);
  assign sum4            = {1'b0, cons_r} + (CONS_W + 1)'(CHUNK_HDR_BYTES);
  assign sum3            = {1'b0, cons_r} + (CONS_W + 1)'(TRIPLET_BYTES);
  assign cons4           = (sum4 > {1'b0, CONSUMED_MAX}) ? CONSUMED_MAX : sum4[CONS_W-1:0];
  assign cons3           = (sum3 > {1'b0, CONSUMED_MAX}) ? CONSUMED_MAX : sum3[CONS_W-1:0];

  always_comb begin
    phase_nxt   = phase_r;
    hidx_nxt    = hidx_r;
    size_nxt    = size_r;
    cons_nxt    = cons_r;
    clear_nxt   = clear_r;
    colored_nxt = colored_r;
    latch_nxt   = latch_r;
    pos_nxt     = pos_r;
    ovf_nxt     = ovf_r;
    emit        = '0;
    if (record_start) begin
      phase_nxt   = PH_KEY;
      hidx_nxt    = 2'd1;
      size_nxt    = '0;
      cons_nxt    = '0;
      clear_nxt   = '0;
      colored_nxt = '0;
      latch_nxt   = '0;
      pos_nxt     = '0;
      ovf_nxt     = 1'b0;
    end else begin
      unique case (phase_r)
        PH_KEY: begin
          hidx_nxt = hidx_r + 2'd1;
          if (hidx_r >= 2'd2) begin
            hidx_nxt  = 2'd0;
            phase_nxt = PH_SIZE;
          end
        end
        PH_SIZE: begin
          if (hidx_r == 2'd0) begin
            size_nxt = {8'h00, data_byte};
            hidx_nxt = 2'd1;
          end else begin
            size_nxt = {data_byte, size_r[7:0]};
            hidx_nxt = 2'd0;
            if ({data_byte, size_r[7:0]} == '0) begin
              emit.cnt = 2'd1;
              emit.run[0] = '{CHAN_FULL, CHAN_ZERO, CHAN_FULL, CHAN_ZERO,
                              RUN_W'(avail), 1'b1, ovf_r};
              pos_nxt   = TOTAL_P;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_CHUNK;
            end
          end
        end
        PH_CHUNK: begin
          unique case (hidx_r)
            2'd0: clear_nxt   = {8'h00, data_byte};
            2'd1: clear_nxt   = {data_byte, clear_r[7:0]};
            2'd2: colored_nxt = {8'h00, data_byte};
            default: ;
          endcase
          hidx_nxt = hidx_r + 2'd1;
          if (hidx_r == 2'd3) begin
            colored_nxt = colored_full;
            cons_nxt    = cons4;
            ovf_nxt     = ovf_r | clip;
            hidx_nxt    = 2'd0;
            pos_nxt     = pos_after_trans;
            if (trans_len != '0) begin
              emit.cnt = 2'd1;
              emit.run[0] = '{CHAN_ZERO, CHAN_ZERO, CHAN_ZERO, CHAN_ZERO,
                              RUN_W'(trans_len), 1'b0, ovf_r | clip};
            end
            if (colored_full == '0) begin
              clear_nxt   = '0;
              colored_nxt = '0;
              if (cons4 >= CONS_W'(size_r)) begin
                emit.run[emit.cnt[0]] = '{CHAN_FULL, CHAN_ZERO, CHAN_FULL, CHAN_ZERO,
                                          RUN_W'(TOTAL_P - pos_after_trans), 1'b1,
                                          ovf_r | clip};
                emit.cnt  = emit.cnt + 2'd1;
                pos_nxt   = TOTAL_P;
                phase_nxt = PH_DONE;
              end
            end else begin
              phase_nxt = PH_PIX;
            end
          end
        end
        PH_PIX: begin
          if (hidx_r == 2'd0) begin
            latch_nxt = {8'h00, data_byte};
            hidx_nxt  = 2'd1;
          end else if (hidx_r == 2'd1) begin
            latch_nxt = {data_byte, latch_r[7:0]};
            hidx_nxt  = 2'd2;
          end else begin
            if (pix_room) begin
              emit.cnt = 2'd1;
              emit.run[0] = '{latch_r[7:0], latch_r[15:8], data_byte, CHAN_FULL,
                              RUN_W'(1), 1'b0, ovf_r};
            end else begin
              ovf_nxt = 1'b1;
            end
            pos_nxt     = pos_after_pix;
            cons_nxt    = cons3;
            hidx_nxt    = 2'd0;
            colored_nxt = colored_dec;
            if (colored_dec == '0) begin
              clear_nxt = '0;
              if (cons3 >= CONS_W'(size_r)) begin
                emit.run[emit.cnt[0]] = '{CHAN_FULL, CHAN_ZERO, CHAN_FULL, CHAN_ZERO,
                                          RUN_W'(TOTAL_P - pos_after_pix), 1'b1,
                                          ovf_r | !pix_room};
                emit.cnt  = emit.cnt + 2'd1;
                pos_nxt   = TOTAL_P;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_CHUNK;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    emit_o = emit;
    if (!accept) begin
      emit_o.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hidx_r    <= '0;
      size_r    <= '0;
      cons_r    <= '0;
      clear_r   <= '0;
      colored_r <= '0;
      latch_r   <= '0;
      pos_r     <= '0;
      ovf_r     <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hidx_r    <= hidx_nxt;
      size_r    <= size_nxt;
      cons_r    <= cons_nxt;
      clear_r   <= clear_nxt;
      colored_r <= colored_nxt;
      latch_r   <= latch_nxt;
      pos_r     <= pos_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= TOTAL_P)
    else $error("pixel position beyond image");

  a_second_is_fill: assert property (@(posedge clk) disable iff (!rst_n)
    emit_o.cnt == 2'd2 |-> emit_o.run[1].end_of_image && !emit_o.run[0].end_of_image)
    else $error("second run of a byte is not the closing fill");

  a_done_full: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> pos_r == TOTAL_P)
    else $error("image finished without being full");

endmodule

// ===== design/rsd_out_fifo.sv =====
// small result queue: takes up to two runs per cycle, hands out one
// depends on rsd_pkg
module rsd_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  rsd_pkg::rsd_emit_t wr_i,
  output logic               room_o,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output rsd_pkg::rsd_run_t  rd_data_o
);
  import rsd_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

  rsd_run_t          slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_FW-1:0] count_r, count_nxt;
  logic              pop;

  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_valid_o = count_r != '0;
  assign rd_data_o  = slot_r[rd_ptr_r];
  assign room_o     = count_r <= CNT_FW'(FIFO_DEPTH - 2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(wr_i.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_FW'(wr_i.cnt) - CNT_FW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.cnt != 2'd0) begin
      slot_r[wr_ptr_r] <= wr_i.run[0];
    end
    if (wr_i.cnt == 2'd2) begin
      slot_r[wr_ptr_r + PTR_W'(1)] <= wr_i.run[1];
    end
  end

endmodule

// ===== design/rle_sprite_pixel_decoder_core.sv =====
// a run is written into the result queue with the byte transfer that causes it
// throughput: one byte per cycle while the result queue has room; the two runs of one byte
//   leave one by one via the single-read queue (four entries, byte taken while two are free)
// reset: synchronous active-low rst_n clears parser state and the queue
// depends on rsd_pkg, rsd_decoder, rsd_out_fifo
module rle_sprite_pixel_decoder_core #(
  parameter int IMAGE_SIDE = rsd_pkg::IMAGE_SIDE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_record_start,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  output logic [7:0]                out_alpha,
  output logic [rsd_pkg::RUN_W-1:0] out_run_length,
  output logic                      out_end_of_image,
  output logic                      out_overflow
);
  import rsd_pkg::*;

  logic      accept;
  rsd_emit_t emit;
  rsd_run_t  head;

  assign accept = in_valid && in_ready;

  rsd_decoder #(
    .IMAGE_SIDE(IMAGE_SIDE)
  ) u_dec (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .record_start (in_record_start),
    .emit_o       (emit)
  );

  rsd_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_i       (emit),
    .room_o     (in_ready),
    .rd_valid_o (out_valid),
    .rd_ready_i (out_ready),
    .rd_data_o  (head)
  );

  assign out_red          = head.red;
  assign out_green        = head.green;
  assign out_blue         = head.blue;
  assign out_alpha        = head.alpha;
  assign out_run_length   = head.run_length;
  assign out_end_of_image = head.end_of_image;
  assign out_overflow     = head.overflow;

endmodule

// ===== bench/rle_sprite_pixel_decoder_core_tb.sv =====
// testbench for rle_sprite_pixel_decoder_core: sprite record bytes in, pixel runs out,
// every run checked against a run-length decoder predictor kept in the bench
// depends on rsd_pkg and rle_sprite_pixel_decoder_core
module rle_sprite_pixel_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsd_pkg::*;

  localparam int PIXELS = IMAGE_SIDE_DEF * IMAGE_SIDE_DEF;

  typedef struct {
    logic [7:0] data;
    logic       start;
    int         gap;
    bit         drain;
  } byte_xfer_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_data_byte = 8'h00;
  logic                in_record_start = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_red;
  logic [7:0]          out_green;
  logic [7:0]          out_blue;
  logic [7:0]          out_alpha;
  logic [RUN_W-1:0]    out_run_length;
  logic                out_end_of_image;
  logic                out_overflow;

  byte_xfer_t bytes_pending[$];
  rsd_run_t   runs_due[$];
  int         bytes_taken = 0;
  int         errors = 0;
  int         hold_at = 0;
  int         tx_wait = 0;
  int         rx_wait = 0;
  bit         hold_rx = 1'b0;
  bit         rx_calm = 1'b0;

  // decoder state mirrored by the predictor
  rsd_phase_t        dec_phase;
  logic [1:0]        dec_idx;
  logic [CNT_W-1:0]  dec_size;
  logic [CONS_W-1:0] dec_used;
  logic [CNT_W-1:0]  dec_clear;
  logic [CNT_W-1:0]  dec_colors_left;
  logic [15:0]       dec_color;
  logic [RUN_W-1:0]  dec_pos;
  bit                dec_ovf;

  rle_sprite_pixel_decoder_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_record_start  (in_record_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_run_length   (out_run_length),
    .out_end_of_image (out_end_of_image),
    .out_overflow     (out_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic decoder_clear();
    dec_phase       = PH_IDLE;
    dec_idx         = '0;
    dec_size        = '0;
    dec_used        = '0;
    dec_clear       = '0;
    dec_colors_left = '0;
    dec_color       = '0;
    dec_pos         = '0;
    dec_ovf         = 1'b0;
  endtask

  task automatic emit_run(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                          input logic [7:0] a, input int len, input logic eoi);
    rsd_run_t run;
    run.red          = r;
    run.green        = g;
    run.blue         = b;
    run.alpha        = a;
    run.run_length   = len[RUN_W-1:0];
    run.end_of_image = eoi;
    run.overflow     = dec_ovf;
    runs_due.push_back(run);
  endtask

  task automatic count_bytes(input int n);
    int s;
    s = int'(dec_used) + n;
    dec_used = (s > int'(CONSUMED_MAX)) ? CONSUMED_MAX : s[CONS_W-1:0];
  endtask

  task automatic fill_image();
    int room;
    room = (dec_pos < PIXELS) ? PIXELS - int'(dec_pos) : 0;
    emit_run(CHAN_FULL, CHAN_ZERO, CHAN_FULL, CHAN_ZERO, room, 1'b1);
    dec_pos   = RUN_W'(PIXELS);
    dec_phase = PH_DONE;
  endtask

  task automatic close_chunk();
    dec_idx         = '0;
    dec_clear       = '0;
    dec_colors_left = '0;
    if (dec_used >= CONS_W'(dec_size)) begin
      fill_image();
    end else begin
      dec_phase = PH_CHUNK;
    end
  endtask

  task automatic decode_byte(input logic [7:0] d, input logic st);
    int room;
    int len;
    if (st) begin
      decoder_clear();
      dec_phase = PH_KEY;
      dec_idx   = 2'd1;
    end else begin
      case (dec_phase)
        PH_KEY: begin
          dec_idx = dec_idx + 2'd1;
          if (dec_idx == 2'd3) begin
            dec_idx   = '0;
            dec_phase = PH_SIZE;
          end
        end
        PH_SIZE: begin
          if (dec_idx == 2'd0) begin
            dec_size = {8'h00, d};
            dec_idx  = 2'd1;
          end else begin
            dec_size[15:8] = d;
            dec_idx        = '0;
            if (dec_size == '0) begin
              fill_image();
            end else begin
              dec_phase = PH_CHUNK;
            end
          end
        end
        PH_CHUNK: begin
          if (dec_idx != 2'd3) begin
            case (dec_idx)
              2'd0:    dec_clear = {8'h00, d};
              2'd1:    dec_clear[15:8] = d;
              default: dec_colors_left = {8'h00, d};
            endcase
            dec_idx = dec_idx + 2'd1;
          end else begin
            dec_colors_left[15:8] = d;
            count_bytes(int'(CHUNK_HDR_BYTES));
            room = (dec_pos < PIXELS) ? PIXELS - int'(dec_pos) : 0;
            len  = int'(dec_clear);
            if (len > room) begin
              len     = room;
              dec_ovf = 1'b1;
            end
            if (len > 0) begin
              emit_run(CHAN_ZERO, CHAN_ZERO, CHAN_ZERO, CHAN_ZERO, len, 1'b0);
              dec_pos = dec_pos + len[RUN_W-1:0];
            end
            dec_idx = '0;
            if (dec_colors_left == '0) begin
              close_chunk();
            end else begin
              dec_phase = PH_PIX;
            end
          end
        end
        PH_PIX: begin
          if (dec_idx == 2'd0) begin
            dec_color = {8'h00, d};
            dec_idx   = 2'd1;
          end else if (dec_idx == 2'd1) begin
            dec_color[15:8] = d;
            dec_idx         = 2'd2;
          end else begin
            if (dec_pos < PIXELS) begin
              emit_run(dec_color[7:0], dec_color[15:8], d, CHAN_FULL, 1, 1'b0);
              dec_pos = dec_pos + RUN_W'(1);
            end else begin
              dec_ovf = 1'b1;
            end
            count_bytes(int'(TRIPLET_BYTES));
            dec_idx         = '0;
            dec_colors_left = dec_colors_left - CNT_W'(1);
            if (dec_colors_left == '0) begin
              close_chunk();
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic send(input logic [7:0] d, input logic st, input int gmax, input bit drain);
    byte_xfer_t x;
    x.data  = d;
    x.start = st;
    x.gap   = $urandom_range(0, gmax);
    x.drain = drain;
    bytes_pending.push_back(x);
  endtask

  task automatic send16(input int v, input int gmax);
    send(v[7:0], 1'b0, gmax, 1'b0);
    send(v[15:8], 1'b0, gmax, 1'b0);
  endtask

  task automatic random_record(input int gmax, input bit drain);
    logic [7:0] rec[$];
    int         n_chunks;
    int         clr;
    int         col;
    int         total;
    int         last;
    int         size_v;
    int         mode;
    int         cut;
    total    = 0;
    last     = 0;
    n_chunks = $urandom_range(1, 4);
    for (int c = 0; c < n_chunks; c++) begin
      case ($urandom_range(0, 9))
        0:       clr = $urandom_range(0, 65535);
        1:       clr = $urandom_range(300, 1100);
        default: clr = $urandom_range(0, 40);
      endcase
      col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      rec.push_back(clr[7:0]);
      rec.push_back(clr[15:8]);
      rec.push_back(col[7:0]);
      rec.push_back(col[15:8]);
      for (int k = 0; k < 3 * col; k++) rec.push_back(8'($urandom_range(0, 255)));
      last  = 4 + 3 * col;
      total = total + last;
    end
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      size_v = 0;
    end else if (mode < 3) begin
      size_v = $urandom_range(1, 65535);
    end else if (mode < 6) begin
      size_v = total - int'($urandom_range(0, last - 1));
    end else begin
      size_v = total;
    end
    // truncated record, dropped by the next start
    if (mode == 19) begin
      cut = $urandom_range(0, rec.size() - 1);
      while (rec.size() > cut) void'(rec.pop_back());
    end
    send(8'($urandom_range(0, 255)), 1'b1, gmax, drain);
    send(8'($urandom_range(0, 255)), 1'b0, gmax, 1'b0);
    send(8'($urandom_range(0, 255)), 1'b0, gmax, 1'b0);
    send16(size_v, gmax);
    foreach (rec[i]) send(rec[i], 1'b0, gmax, 1'b0);
  endtask

  always @(posedge clk) begin
    byte_xfer_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
      decoder_clear();
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_data_byte, in_record_start);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (bytes_pending.size() == 0 || (bytes_pending[0].drain && runs_due.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (tx_wait < bytes_pending[0].gap) begin
          in_valid <= 1'b0;
          tx_wait  <= tx_wait + 1;
        end else begin
          nxt = bytes_pending.pop_front();
          in_valid        <= 1'b1;
          in_data_byte    <= nxt.data;
          in_record_start <= nxt.start;
          tx_wait         <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsd_run_t got;
    rsd_run_t want;
    int       w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else begin
      w = rx_wait;
      if (out_valid && out_ready) begin
        got.red          = out_red;
        got.green        = out_green;
        got.blue         = out_blue;
        got.alpha        = out_alpha;
        got.run_length   = out_run_length;
        got.end_of_image = out_end_of_image;
        got.overflow     = out_overflow;
        if (runs_due.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected run: %p", got);
        end else begin
          want = runs_due.pop_front();
          if (got !== want) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("run mismatch: expected rgba %h %h %h %h len %0d eoi %b ovf %b",
                       want.red, want.green, want.blue, want.alpha, want.run_length,
                       want.end_of_image, want.overflow,
                       " got rgba %h %h %h %h len %0d eoi %b ovf %b",
                       got.red, got.green, got.blue, got.alpha, got.run_length,
                       got.end_of_image, got.overflow);
            end
          end
        end
        w = rx_calm ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 149) == 0) rx_calm <= !rx_calm;
      end
      if (hold_rx) begin
        out_ready <= 1'b0;
      end else if (w == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        w = w - 1;
      end
      rx_wait <= w;
    end
  end

  // long receiver hold-off so the result queue fills and backs up the input
  initial begin
    while (hold_at == 0 || bytes_taken < hold_at) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (120) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int  target;
    int  gmax;
    bit  first;

    // bytes outside a record, zero size, restart, clipped run, dropped pixel, full image
    send(8'hFF, 1'b0, 8, 1'b0);
    send(8'h00, 1'b1, 8, 1'b0);
    send(8'hFF, 1'b0, 8, 1'b0);
    send(8'h00, 1'b0, 8, 1'b0);
    send16(0, 8);
    send(8'h80, 1'b0, 8, 1'b0);
    send(8'h5A, 1'b1, 8, 1'b0);
    send(8'h34, 1'b0, 8, 1'b0);
    send(8'hA5, 1'b1, 8, 1'b1);
    send(8'h01, 1'b0, 8, 1'b0);
    send(8'hFE, 1'b0, 8, 1'b0);
    send16(7, 8);
    send16(16'hFFFF, 8);
    send16(1, 8);
    send(8'hAB, 1'b0, 8, 1'b0);
    send(8'hCD, 1'b0, 8, 1'b0);
    send(8'hEF, 1'b0, 8, 1'b0);

    hold_at = bytes_pending.size() + 250;
    target  = bytes_pending.size() + 1500;
    first   = 1'b1;
    while (bytes_pending.size() < target) begin
      gmax = ($urandom_range(0, 3) == 0) ? 0 : 8;
      random_record(gmax, first || ($urandom_range(0, 7) == 0));
      first = 1'b0;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send(8'($urandom_range(0, 255)), 1'b0, gmax, 1'b0);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_pending.size() != 0 || in_valid) @(posedge clk);
    while (runs_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (runs_due.size() != 0) begin
      $display("%0d expected runs never came out", runs_due.size());
      errors = errors + runs_due.size();
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
